>>> src/char_lcd_4bit_write_sequencer_top_defines.svh
// Assertion macros shared by the LCD write sequencer RTL.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef CHAR_LCD_4BIT_WRITE_SEQUENCER_TOP_DEFINES_SVH
`define CHAR_LCD_4BIT_WRITE_SEQUENCER_TOP_DEFINES_SVH

// Property that must hold at every edge out of reset
`define CLSEQ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition that, when seen, forces a consequence on the following edge
`define CLSEQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/clseq_pkg.sv
// Shared types and constants for the 4-bit character LCD write sequencer.
// No dependencies.
package clseq_pkg;

    localparam int TIMER_WIDTH_DEFAULT = 16;
    localparam int CFG_WIDTH           = 16;
    localparam int ADDR_WIDTH          = 5;

    // Request codes carried in the operation field
    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_CMD    = 3'd1,
        OP_DATA   = 3'd2,
        OP_CURSOR = 3'd3,
        OP_INIT   = 3'd4
    } op_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_PULSE      = 3'd0,
        REG_SETTLE     = 3'd1,
        REG_CLEAR_HOME = 3'd2,
        REG_POWER_UP   = 3'd3,
        REG_INIT_LONG  = 3'd4,
        REG_INIT_SHORT = 3'd5
    } reg_idx_t;

    // Sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_HI_HIGH   = 4'd1,
        PH_HI_LOW    = 4'd2,
        PH_LO_HIGH   = 4'd3,
        PH_LO_LOW    = 4'd4,
        PH_SETTLE    = 4'd5,
        PH_POWER     = 4'd6,
        PH_INIT_HIGH = 4'd7,
        PH_INIT_LOW  = 4'd8,
        PH_INIT_WAIT = 4'd9
    } phase_t;

    localparam logic [7:0] SET_DDRAM_ADDR = 8'h80;
    localparam logic [7:0] ROW1_BASE      = 8'h40;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_HOME       = 8'h02;
    localparam logic [3:0] NIB_WAKE       = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT   = 4'h2;

    // Init step numbering: 1..4 wake-up nibbles, 5..8 setup bytes
    localparam logic [3:0] STEP_NONE       = 4'd0;
    localparam logic [3:0] STEP_FIRST_NIB  = 4'd1;
    localparam logic [3:0] STEP_LAST_NIB   = 4'd4;
    localparam logic [3:0] STEP_FIRST_BYTE = 4'd5;
    localparam logic [3:0] STEP_LAST_CHAIN = 4'd7;

    // One result item
    typedef struct packed {
        logic       rs;
        logic       enable;
        logic [3:0] nibble;
        logic       busy;
        logic       rejected;
    } result_t;

    // Setup bytes sent after the wake-up nibbles
    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h28;
            2'd1:    b = 8'h0C;
            2'd2:    b = 8'h06;
            default: b = 8'h01;
        endcase
        return b;
    endfunction

endpackage

>>> src/char_lcd_4bit_write_sequencer_top.sv
// Character LCD write sequencer for a 4-bit bus: top level.
// Depends on clseq_pkg and char_lcd_4bit_write_sequencer_top_defines.svh.
//
// Each input item is a tick or a request (command byte, data byte, cursor
// set, power-up init) and yields exactly one result item holding the bus
// levels after it. One item is accepted every cycle while s_ready is high;
// its result is registered on the m_ side, taken from a single-pass update
// of the phase state machine and its countdown. A one-item skid register lets
// an item still be accepted while a result waits, so s_ready only drops after
// two results are held. Requests that arrive during a sequence are dropped
// and flagged as rejected. Timing registers sit on an APB port at 4*index;
// a value of 0 counts as 1 and values saturate to TIMER_WIDTH bits.
`include "char_lcd_4bit_write_sequencer_top_defines.svh"

module char_lcd_4bit_write_sequencer_top #(
    parameter int TIMER_WIDTH = clseq_pkg::TIMER_WIDTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [clseq_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_operation,
    input  logic [7:0]                    s_byte_value,
    input  logic                          s_row,
    input  logic [5:0]                    s_column,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_rs_pin,
    output logic                          m_enable_pin,
    output logic [3:0]                    m_data_nibble,
    output logic                          m_busy_res,
    output logic                          m_rejected
);

    localparam int CW = clseq_pkg::CFG_WIDTH;
    localparam logic [32:0] TMAX = (33'd1 << TIMER_WIDTH) - 33'd1;

    // configuration registers
    logic [CW-1:0] pulse_reg, settle_reg, clear_home_reg;
    logic [CW-1:0] power_up_reg, init_long_reg, init_short_reg;

    // sequencer state
    clseq_pkg::phase_t      phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0] count_reg, count_next;
    logic [7:0]             byte_reg, byte_next;
    logic                   sel_reg, sel_next;
    logic [3:0]             step_reg, step_next;
    logic                   enable_reg, enable_next;
    logic [3:0]             nibble_reg, nibble_next;
    logic                   rej_next;

    // output and skid stages
    clseq_pkg::result_t out_reg, skid_reg, result;
    logic               m_valid_reg, skid_valid_reg;

    logic              s_fire, m_fire, cfg_write, busy, is_request;
    clseq_pkg::op_t    op;
    clseq_pkg::reg_idx_t cfg_idx;

    // Turn a register value into a countdown load: zero counts as one
    function automatic logic [TIMER_WIDTH-1:0] load_time(input logic [CW-1:0] v);
        logic [32:0] ext;
        ext = {{(33-CW){1'b0}}, v};
        if (ext == 33'd0) begin
            ext = 33'd1;
        end else if (ext > TMAX) begin
            ext = TMAX;
        end
        return ext[TIMER_WIDTH-1:0];
    endfunction

    assign op         = clseq_pkg::op_t'(s_operation);
    assign busy       = (phase_reg != clseq_pkg::PH_IDLE);
    assign s_ready    = !skid_valid_reg;
    assign s_fire     = s_valid && s_ready;
    assign m_fire     = m_valid_reg && m_ready;
    assign is_request = (op == clseq_pkg::OP_CMD) || (op == clseq_pkg::OP_DATA) ||
                        (op == clseq_pkg::OP_CURSOR) || (op == clseq_pkg::OP_INIT);

    // APB access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = clseq_pkg::reg_idx_t'(paddr[clseq_pkg::ADDR_WIDTH-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_reg      <= CW'(100);
            settle_reg     <= CW'(100);
            clear_home_reg <= CW'(2000);
            power_up_reg   <= CW'(50000);
            init_long_reg  <= CW'(5000);
            init_short_reg <= CW'(150);
        end else if (cfg_write) begin
            unique case (cfg_idx)
                clseq_pkg::REG_PULSE:      pulse_reg      <= pwdata[CW-1:0];
                clseq_pkg::REG_SETTLE:     settle_reg     <= pwdata[CW-1:0];
                clseq_pkg::REG_CLEAR_HOME: clear_home_reg <= pwdata[CW-1:0];
                clseq_pkg::REG_POWER_UP:   power_up_reg   <= pwdata[CW-1:0];
                clseq_pkg::REG_INIT_LONG:  init_long_reg  <= pwdata[CW-1:0];
                clseq_pkg::REG_INIT_SHORT: init_short_reg <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            clseq_pkg::REG_PULSE:      prdata[CW-1:0] = pulse_reg;
            clseq_pkg::REG_SETTLE:     prdata[CW-1:0] = settle_reg;
            clseq_pkg::REG_CLEAR_HOME: prdata[CW-1:0] = clear_home_reg;
            clseq_pkg::REG_POWER_UP:   prdata[CW-1:0] = power_up_reg;
            clseq_pkg::REG_INIT_LONG:  prdata[CW-1:0] = init_long_reg;
            clseq_pkg::REG_INIT_SHORT: prdata[CW-1:0] = init_short_reg;
            default:                   prdata = '0;
        endcase
    end

    // Next state: decode a request or advance on a tick
    always_comb begin
        logic       start_en;
        logic [7:0] start_byte;
        logic       start_sel;
        logic [7:0] cursor_addr;

        start_en    = 1'b0;
        start_byte  = 8'h00;
        start_sel   = 1'b0;
        cursor_addr = (s_row ? clseq_pkg::ROW1_BASE : 8'h00) + {2'b00, s_column};

        phase_next  = phase_reg;
        count_next  = count_reg;
        byte_next   = byte_reg;
        sel_next    = sel_reg;
        step_next   = step_reg;
        enable_next = enable_reg;
        nibble_next = nibble_reg;
        rej_next    = 1'b0;

        if (op == clseq_pkg::OP_TICK) begin
            if (busy && count_reg > TIMER_WIDTH'(1)) begin
                count_next = count_reg - TIMER_WIDTH'(1);
            end else if (busy) begin
                unique case (phase_reg)
                    clseq_pkg::PH_HI_HIGH: begin
                        enable_next = 1'b0;
                        phase_next  = clseq_pkg::PH_HI_LOW;
                        count_next  = load_time(pulse_reg);
                    end
                    clseq_pkg::PH_LO_HIGH: begin
                        enable_next = 1'b0;
                        phase_next  = clseq_pkg::PH_LO_LOW;
                        count_next  = load_time(pulse_reg);
                    end
                    clseq_pkg::PH_INIT_HIGH: begin
                        enable_next = 1'b0;
                        phase_next  = clseq_pkg::PH_INIT_LOW;
                        count_next  = load_time(pulse_reg);
                    end
                    clseq_pkg::PH_HI_LOW: begin
                        nibble_next = byte_reg[3:0];
                        enable_next = 1'b1;
                        phase_next  = clseq_pkg::PH_LO_HIGH;
                        count_next  = load_time(pulse_reg);
                    end
                    clseq_pkg::PH_LO_LOW: begin
                        phase_next = clseq_pkg::PH_SETTLE;
                        if (!sel_reg && (byte_reg == clseq_pkg::CMD_CLEAR ||
                                         byte_reg == clseq_pkg::CMD_HOME)) begin
                            count_next = load_time(clear_home_reg);
                        end else begin
                            count_next = load_time(settle_reg);
                        end
                    end
                    clseq_pkg::PH_SETTLE: begin
                        if (step_reg >= clseq_pkg::STEP_FIRST_BYTE &&
                            step_reg <= clseq_pkg::STEP_LAST_CHAIN) begin
                            step_next  = step_reg + 4'd1;
                            start_en   = 1'b1;
                            start_byte = clseq_pkg::init_byte(step_reg[1:0]);
                        end else begin
                            step_next  = clseq_pkg::STEP_NONE;
                            phase_next = clseq_pkg::PH_IDLE;
                            count_next = '0;
                        end
                    end
                    clseq_pkg::PH_POWER: begin
                        nibble_next = clseq_pkg::NIB_WAKE;
                        enable_next = 1'b1;
                        phase_next  = clseq_pkg::PH_INIT_HIGH;
                        count_next  = load_time(pulse_reg);
                    end
                    clseq_pkg::PH_INIT_LOW: begin
                        phase_next = clseq_pkg::PH_INIT_WAIT;
                        count_next = (step_reg == clseq_pkg::STEP_FIRST_NIB) ?
                                     load_time(init_long_reg) : load_time(init_short_reg);
                    end
                    clseq_pkg::PH_INIT_WAIT: begin
                        if (step_reg >= clseq_pkg::STEP_FIRST_NIB &&
                            step_reg < clseq_pkg::STEP_LAST_NIB) begin
                            step_next   = step_reg + 4'd1;
                            nibble_next = (step_reg == clseq_pkg::STEP_LAST_NIB - 4'd1) ?
                                          clseq_pkg::NIB_FOUR_BIT : clseq_pkg::NIB_WAKE;
                            enable_next = 1'b1;
                            phase_next  = clseq_pkg::PH_INIT_HIGH;
                            count_next  = load_time(pulse_reg);
                        end else begin
                            step_next  = clseq_pkg::STEP_FIRST_BYTE;
                            start_en   = 1'b1;
                            start_byte = clseq_pkg::init_byte(2'd0);
                        end
                    end
                    default: begin
                        phase_next  = clseq_pkg::PH_IDLE;
                        enable_next = 1'b0;
                        step_next   = clseq_pkg::STEP_NONE;
                        count_next  = '0;
                    end
                endcase
            end
        end else if (is_request && busy) begin
            rej_next = 1'b1;
        end else begin
            unique case (op)
                clseq_pkg::OP_CMD: begin
                    start_en   = 1'b1;
                    start_byte = s_byte_value;
                end
                clseq_pkg::OP_DATA: begin
                    start_en   = 1'b1;
                    start_byte = s_byte_value;
                    start_sel  = 1'b1;
                end
                clseq_pkg::OP_CURSOR: begin
                    start_en   = 1'b1;
                    start_byte = clseq_pkg::SET_DDRAM_ADDR | cursor_addr;
                end
                clseq_pkg::OP_INIT: begin
                    sel_next    = 1'b0;
                    enable_next = 1'b0;
                    step_next   = clseq_pkg::STEP_FIRST_NIB;
                    phase_next  = clseq_pkg::PH_POWER;
                    count_next  = load_time(power_up_reg);
                end
                default: ;
            endcase
        end

        // Load the high nibble of a byte and raise enable
        if (start_en) begin
            byte_next   = start_byte;
            sel_next    = start_sel;
            nibble_next = start_byte[7:4];
            enable_next = 1'b1;
            phase_next  = clseq_pkg::PH_HI_HIGH;
            count_next  = load_time(pulse_reg);
        end
    end

    // Result item: bus levels after the item
    always_comb begin
        result.rs       = sel_next;
        result.enable   = enable_next;
        result.nibble   = nibble_next;
        result.busy     = (phase_next != clseq_pkg::PH_IDLE);
        result.rejected = rej_next;
    end

    // Commit state on an accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= clseq_pkg::PH_IDLE;
            count_reg  <= '0;
            byte_reg   <= '0;
            sel_reg    <= 1'b0;
            step_reg   <= clseq_pkg::STEP_NONE;
            enable_reg <= 1'b0;
            nibble_reg <= '0;
        end else if (s_fire) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            byte_reg   <= byte_next;
            sel_reg    <= sel_next;
            step_reg   <= step_next;
            enable_reg <= enable_next;
            nibble_reg <= nibble_next;
        end
    end

    // Output register with a one-item skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg    <= skid_valid_reg || s_fire;
            skid_valid_reg <= 1'b0;
        end else if (s_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        if (s_fire && m_valid_reg && !m_ready) begin
            skid_reg <= result;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_rs_pin      = out_reg.rs;
    assign m_enable_pin  = out_reg.enable;
    assign m_data_nibble = out_reg.nibble;
    assign m_busy_res    = out_reg.busy;
    assign m_rejected    = out_reg.rejected;

    // Checks
    `CLSEQ_ASSERT(a_skid_behind_out, !skid_valid_reg || m_valid_reg, "skid item without output item")
    `CLSEQ_ASSERT(a_idle_enable_low, busy || !enable_reg, "enable high while idle")
    `CLSEQ_ASSERT_NEXT(a_reject_holds, s_fire && busy && is_request, phase_reg == $past(phase_reg) && count_reg == $past(count_reg), "rejected request changed state")
    `CLSEQ_ASSERT_NEXT(a_fire_shows, s_fire && !m_valid_reg, m_valid_reg, "accepted item produced no result")

endmodule

>>> test/char_lcd_4bit_write_sequencer_top_tb.sv
// Self-checking testbench for the 4-bit character LCD write sequencer.
// Needs clseq_pkg and the top level; compares every result item against a
// built-in predictor of the bus levels, or against the typed script levels.
module char_lcd_4bit_write_sequencer_top_tb;
    import clseq_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 64;
    localparam int TIMER_W     = TIMER_WIDTH_DEFAULT;

    // Operation codes the block must ignore
    localparam logic [2:0] OP_UNUSED_LO = OP_INIT + 3'd1;
    localparam logic [2:0] OP_UNUSED_HI = '1;

    // Bytes that follow the wake-up nibbles during init
    localparam logic [7:0] SETUP_SEQ [4] = '{8'h28, 8'h0C, 8'h06, CMD_CLEAR};

    // Bus levels that can be read off directly
    localparam result_t LEVELS_REST   = '{rs: 1'b0, enable: 1'b0, nibble: 4'h0,
                                          busy: 1'b0, rejected: 1'b0};
    localparam result_t LEVELS_FF     = '{rs: 1'b0, enable: 1'b1, nibble: 4'hF,
                                          busy: 1'b1, rejected: 1'b0};
    localparam result_t LEVELS_FF_REJ = '{rs: 1'b0, enable: 1'b1, nibble: 4'hF,
                                          busy: 1'b1, rejected: 1'b1};
    localparam result_t LEVELS_NONE   = '0;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] ch;
        logic       rw;
        logic [5:0] cl;
        logic       typed;
        result_t    want;
        logic       drain;
        logic       retime;
    } script_row_t;

    // Directed script: rows before the retime row run on reset timing
    localparam script_row_t SCRIPT [21] = '{
        '{OP_TICK,      8'h00, 1'b0, 6'd0,  1'b1, LEVELS_REST,   1'b0, 1'b0},
        '{OP_UNUSED_HI, 8'hFF, 1'b1, 6'd63, 1'b1, LEVELS_REST,   1'b0, 1'b0},
        '{OP_CMD,       8'hFF, 1'b0, 6'd0,  1'b1, LEVELS_FF,     1'b0, 1'b0},
        '{OP_DATA,      8'h00, 1'b0, 6'd0,  1'b1, LEVELS_FF_REJ, 1'b0, 1'b0},
        '{OP_CURSOR,    8'h00, 1'b1, 6'd63, 1'b1, LEVELS_FF_REJ, 1'b0, 1'b0},
        '{OP_INIT,      8'h00, 1'b0, 6'd0,  1'b1, LEVELS_FF_REJ, 1'b0, 1'b0},
        '{OP_UNUSED_LO, 8'h5A, 1'b1, 6'd21, 1'b1, LEVELS_FF,     1'b0, 1'b0},
        '{OP_TICK,      8'h00, 1'b0, 6'd0,  1'b0, LEVELS_NONE,   1'b1, 1'b1},
        '{OP_DATA,      CMD_CLEAR, 1'b0, 6'd0, 1'b0, LEVELS_NONE, 1'b1, 1'b0},
        '{OP_CMD,       CMD_CLEAR, 1'b0, 6'd0, 1'b0, LEVELS_NONE, 1'b1, 1'b0},
        '{OP_CMD,       CMD_HOME,  1'b0, 6'd0, 1'b0, LEVELS_NONE, 1'b1, 1'b0},
        '{OP_CURSOR,    8'h00, 1'b1, 6'd63, 1'b0, LEVELS_NONE,   1'b1, 1'b0},
        '{OP_CURSOR,    8'hFF, 1'b0, 6'd0,  1'b0, LEVELS_NONE,   1'b1, 1'b0},
        '{OP_CURSOR,    8'h00, 1'b1, 6'd39, 1'b0, LEVELS_NONE,   1'b1, 1'b0},
        '{OP_DATA,      8'hA5, 1'b0, 6'd0,  1'b0, LEVELS_NONE,   1'b1, 1'b0},
        '{OP_CMD,       8'h00, 1'b0, 6'd0,  1'b0, LEVELS_NONE,   1'b1, 1'b0},
        '{OP_INIT,      8'h00, 1'b0, 6'd0,  1'b0, LEVELS_NONE,   1'b0, 1'b0},
        '{OP_TICK,      8'h00, 1'b0, 6'd0,  1'b0, LEVELS_NONE,   1'b0, 1'b0},
        '{OP_CMD,       8'h28, 1'b0, 6'd0,  1'b0, LEVELS_NONE,   1'b0, 1'b0},
        '{OP_TICK,      8'h00, 1'b0, 6'd0,  1'b0, LEVELS_NONE,   1'b1, 1'b0},
        '{OP_TICK,      8'h00, 1'b0, 6'd0,  1'b0, LEVELS_NONE,   1'b0, 1'b0}
    };

    logic                  aclk;
    logic                  aresetn      = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr        = '0;
    logic [31:0]           pwdata       = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [2:0]            s_operation  = OP_TICK;
    logic [7:0]            s_byte_value = '0;
    logic                  s_row        = 1'b0;
    logic [5:0]            s_column     = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic                  m_rs_pin;
    logic                  m_enable_pin;
    logic [3:0]            m_data_nibble;
    logic                  m_busy_res;
    logic                  m_rejected;

    // Predictor copy of the timing registers and sequencer state
    logic [15:0] timing [6] = '{16'd100, 16'd100, 16'd2000, 16'd50000, 16'd5000, 16'd150};
    phase_t      bus_phase    = PH_IDLE;
    int unsigned phase_left   = 0;
    logic [7:0]  held_char    = '0;
    logic        held_rs      = 1'b0;
    logic [3:0]  init_step_no = STEP_NONE;
    logic        enable_lvl   = 1'b0;
    logic [3:0]  nibble_lvl   = '0;

    result_t bus_levels_due [$];
    result_t due_levels;

    int send_gap_pct    = 0;
    int recv_gap_pct    = 0;
    int hold_asks       = 0;
    int hold_taken      = 0;
    int hold_count      = 0;
    int stall_cycles    = 0;
    int error_count     = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int rejects_due     = 0;
    int settings_used   = 0;

    char_lcd_4bit_write_sequencer_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_byte_value  (s_byte_value),
        .s_row         (s_row),
        .s_column      (s_column),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rs_pin      (m_rs_pin),
        .m_enable_pin  (m_enable_pin),
        .m_data_nibble (m_data_nibble),
        .m_busy_res    (m_busy_res),
        .m_rejected    (m_rejected)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Print one line per mismatch and count it
    task automatic flag_mismatch(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [3:0] got,
                               input logic [3:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                    results_checked, name, got, want));
        end
    endtask

    // Phase length: zero counts as one, saturate to the timer width
    function automatic int unsigned phase_span(input reg_idx_t idx);
        longint unsigned v;
        longint unsigned cap;
        v   = 64'(timing[idx]);
        cap = (64'd1 << TIMER_W) - 64'd1;
        if (v == 64'd0) begin
            v = 64'd1;
        end
        if (v > cap) begin
            v = cap;
        end
        return 32'(v);
    endfunction

    task automatic load_byte(input logic [7:0] b, input logic rs);
        held_char  = b;
        held_rs    = rs;
        nibble_lvl = b[7:4];
        enable_lvl = 1'b1;
        bus_phase  = PH_HI_HIGH;
        phase_left = phase_span(REG_PULSE);
    endtask

    // Work out the bus levels after one item and update the state
    task automatic predict_bus_levels(input logic [2:0] op, input logic [7:0] ch,
                                      input logic rw, input logic [5:0] cl,
                                      output result_t lv);
        bit         busy;
        bit         rej;
        logic [1:0] setup_idx;
        busy = (bus_phase != PH_IDLE);
        rej  = 1'b0;
        if (op == OP_TICK) begin
            if (busy && phase_left > 1) begin
                phase_left--;
            end else if (busy) begin
                // countdown spent: advance to the next phase
                case (bus_phase)
                    PH_HI_HIGH, PH_LO_HIGH, PH_INIT_HIGH: begin
                        enable_lvl = 1'b0;
                        bus_phase  = phase_t'(bus_phase + 4'd1);
                        phase_left = phase_span(REG_PULSE);
                    end
                    PH_HI_LOW: begin
                        nibble_lvl = held_char[3:0];
                        enable_lvl = 1'b1;
                        bus_phase  = PH_LO_HIGH;
                        phase_left = phase_span(REG_PULSE);
                    end
                    PH_LO_LOW: begin
                        bus_phase = PH_SETTLE;
                        if (!held_rs && (held_char == CMD_CLEAR || held_char == CMD_HOME)) begin
                            phase_left = phase_span(REG_CLEAR_HOME);
                        end else begin
                            phase_left = phase_span(REG_SETTLE);
                        end
                    end
                    PH_SETTLE: begin
                        if (init_step_no >= STEP_FIRST_BYTE && init_step_no <= STEP_LAST_CHAIN) begin
                            init_step_no++;
                            setup_idx = 2'(init_step_no - STEP_FIRST_BYTE);
                            load_byte(SETUP_SEQ[setup_idx], 1'b0);
                        end else begin
                            init_step_no = STEP_NONE;
                            bus_phase    = PH_IDLE;
                            phase_left   = 0;
                        end
                    end
                    PH_POWER: begin
                        nibble_lvl = NIB_WAKE;
                        enable_lvl = 1'b1;
                        bus_phase  = PH_INIT_HIGH;
                        phase_left = phase_span(REG_PULSE);
                    end
                    PH_INIT_LOW: begin
                        bus_phase  = PH_INIT_WAIT;
                        phase_left = phase_span(init_step_no == STEP_FIRST_NIB ?
                                                REG_INIT_LONG : REG_INIT_SHORT);
                    end
                    PH_INIT_WAIT: begin
                        if (init_step_no >= STEP_FIRST_NIB && init_step_no < STEP_LAST_NIB) begin
                            init_step_no++;
                            nibble_lvl = (init_step_no == STEP_LAST_NIB) ? NIB_FOUR_BIT : NIB_WAKE;
                            enable_lvl = 1'b1;
                            bus_phase  = PH_INIT_HIGH;
                            phase_left = phase_span(REG_PULSE);
                        end else begin
                            init_step_no = STEP_FIRST_BYTE;
                            load_byte(SETUP_SEQ[0], 1'b0);
                        end
                    end
                    default: begin
                        bus_phase    = PH_IDLE;
                        enable_lvl   = 1'b0;
                        init_step_no = STEP_NONE;
                        phase_left   = 0;
                    end
                endcase
            end
        end else if (op <= OP_INIT) begin
            // drop any request that arrives mid-sequence
            if (busy) begin
                rej = 1'b1;
            end else begin
                case (op)
                    OP_CMD:    load_byte(ch, 1'b0);
                    OP_DATA:   load_byte(ch, 1'b1);
                    OP_CURSOR: load_byte(SET_DDRAM_ADDR | ((rw ? ROW1_BASE : 8'h00) + 8'(cl)),
                                         1'b0);
                    default: begin
                        held_rs      = 1'b0;
                        enable_lvl   = 1'b0;
                        init_step_no = STEP_FIRST_NIB;
                        bus_phase    = PH_POWER;
                        phase_left   = phase_span(REG_POWER_UP);
                    end
                endcase
            end
        end
        lv = '{rs: held_rs, enable: enable_lvl, nibble: nibble_lvl,
               busy: bus_phase != PH_IDLE, rejected: rej};
    endtask

    // Offer one item, hold it until accepted, then queue its bus levels
    task automatic offer_item(input logic [2:0] op, input logic [7:0] ch, input logic rw,
                              input logic [5:0] cl, input bit typed, input result_t want);
        result_t lv;
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_byte_value <= ch;
        s_row        <= rw;
        s_column     <= cl;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_bus_levels(op, ch, rw, cl, lv);
        bus_levels_due.push_back(typed ? want : lv);
        items_accepted++;
        if (lv.rejected) begin
            rejects_due++;
        end
    endtask

    task automatic send_ticks_until_idle();
        while (bus_phase != PH_IDLE) begin
            offer_item(OP_TICK, 8'($urandom), 1'($urandom), 6'($urandom), 1'b0, LEVELS_NONE);
        end
    endtask

    // Wait for all results, then write the six timing registers
    task automatic program_timing(input logic [15:0] pulse, input logic [15:0] settle,
                                  input logic [15:0] clear_home, input logic [15:0] power_up,
                                  input logic [15:0] init_long, input logic [15:0] init_short);
        logic [15:0] vals [6];
        reg_idx_t    idx;
        vals = '{pulse, settle, clear_home, power_up, init_long, init_short};
        s_valid <= 1'b0;
        while (bus_levels_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (2) @(posedge aclk);
        for (int i = 0; i < 6; i++) begin
            idx = reg_idx_t'(i);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= {16'h0000, vals[i]};
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            timing[idx] = vals[i];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    // Random items: mostly requests when idle, mostly ticks while a sequence runs
    task automatic run_random(input int target);
        int         counted;
        int         pick;
        bit         idle;
        logic [2:0] op;
        logic [7:0] ch;
        logic [5:0] cl;
        counted = 0;
        while (counted < target) begin
            idle = (bus_phase == PH_IDLE);
            pick = $urandom_range(99);
            ch   = 8'($urandom);
            cl   = $urandom_range(3) == 0 ? 6'($urandom_range(63)) : 6'($urandom_range(39));
            if (idle) begin
                if (pick < 32) begin
                    op = OP_CMD;
                end else if (pick < 62) begin
                    op = OP_DATA;
                end else if (pick < 80) begin
                    op = OP_CURSOR;
                end else if (pick < 90) begin
                    op = OP_INIT;
                end else if (pick < 95) begin
                    op = OP_TICK;
                end else begin
                    op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
                end
                if ((op == OP_CMD || op == OP_DATA) && $urandom_range(3) == 0) begin
                    ch = $urandom_range(1) ? CMD_CLEAR : CMD_HOME;
                end
            end else if (pick < 86) begin
                op = OP_TICK;
            end else if (pick < 96) begin
                op = 3'($urandom_range(OP_INIT, OP_CMD));
            end else begin
                op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
            end
            offer_item(op, ch, 1'($urandom), cl, 1'b0, LEVELS_NONE);
            if (op <= OP_INIT && !(op == OP_TICK && idle)) begin
                counted++;
            end
        end
    endtask

    // Result side: random stalls, or a long hold-off when asked
    always @(posedge aclk) begin
        if (hold_taken != hold_asks && hold_count == 0) begin
            hold_count = HOLD_CYCLES;
            hold_taken = hold_asks;
        end
        if (hold_count > 0) begin
            hold_count--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // Compare each result item with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (bus_levels_due.size() == 0) begin
                flag_mismatch("result item arrived with nothing expected");
            end else begin
                due_levels = bus_levels_due.pop_front();
                check_field("rs_pin", 4'(m_rs_pin), 4'(due_levels.rs));
                check_field("enable_pin", 4'(m_enable_pin), 4'(due_levels.enable));
                check_field("data_nibble", m_data_nibble, due_levels.nibble);
                check_field("busy_res", 4'(m_busy_res), 4'(due_levels.busy));
                check_field("rejected", 4'(m_rejected), 4'(due_levels.rejected));
                results_checked++;
            end
        end
    end

    // Stop the run if neither channel moves for too long
    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid === 1'b1 && s_ready === 1'b1) ||
                (m_valid === 1'b1 && m_ready === 1'b1)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed script, sender sparse and receiver stalling often
        send_gap_pct = 13;
        recv_gap_pct = 60;
        for (int i = 0; i < $size(SCRIPT); i++) begin
            if (SCRIPT[i].retime) begin
                // zero pulse length must behave as one tick
                program_timing(16'd0, 16'd1, 16'd2, 16'd1, 16'd2, 16'd1);
            end
            offer_item(SCRIPT[i].op, SCRIPT[i].ch, SCRIPT[i].rw, SCRIPT[i].cl,
                       SCRIPT[i].typed, SCRIPT[i].want);
            if (SCRIPT[i].drain) begin
                send_ticks_until_idle();
            end
        end

        // Shortest timing everywhere
        program_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        run_random(200);

        // Swap the idling sides, mixed short timing
        send_gap_pct = 60;
        recv_gap_pct = 13;
        program_timing(16'($urandom_range(6, 1)), 16'($urandom_range(6, 1)),
                       16'($urandom_range(6, 1)), 16'($urandom_range(6, 1)),
                       16'($urandom_range(6, 1)), 16'($urandom_range(6, 1)));
        run_random(200);

        // Full rate; hold the result side off so the input backs up
        send_gap_pct = 0;
        recv_gap_pct = 0;
        program_timing(16'($urandom_range(4)), 16'($urandom_range(4)),
                       16'($urandom_range(4)), 16'($urandom_range(4)),
                       16'($urandom_range(4)), 16'($urandom_range(4)));
        hold_asks++;
        run_random(100);
        hold_asks++;
        run_random(100);

        // Longest waits: load the full count into every phase and poke it while it runs
        program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        offer_item(OP_CMD, CMD_HOME, 1'b0, 6'd0, 1'b0, LEVELS_NONE);
        run_random(40);

        // Drain outstanding results
        s_valid <= 1'b0;
        while (bus_levels_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
        if (bus_levels_due.size() != 0) begin
            flag_mismatch($sformatf("%0d result items never arrived", bus_levels_due.size()));
        end

        $display("covered %0d items over %0d timing settings plus reset timing",
                 items_accepted, settings_used);
        $display("checked %0d result items, %0d requests dropped while busy, %0d mismatches",
                 results_checked, rejects_due, error_count);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
